FILE: src/tea_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tea_pkg;

   localparam int WORD_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = 2;

   // Golden-ratio constant added to the running sum once per round.
   localparam logic [WORD_WIDTH-1:0] DELTA = 32'h9E3779B9;

   localparam logic FUNC_ENCRYPT = 1'b0;
   localparam logic FUNC_DECRYPT = 1'b1;

   localparam logic [CSR_INDEX_WIDTH-1:0] KEY_WORD_0_INDEX = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] KEY_WORD_1_INDEX = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] KEY_WORD_2_INDEX = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] KEY_WORD_3_INDEX = 2'd3;

   typedef struct packed {
      logic                  func;
      logic [WORD_WIDTH-1:0] a;
      logic [WORD_WIDTH-1:0] b;
   } item_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] k0;
      logic [WORD_WIDTH-1:0] k1;
      logic [WORD_WIDTH-1:0] k2;
      logic [WORD_WIDTH-1:0] k3;
   } key_type;

   function automatic logic [WORD_WIDTH-1:0] mix_half(
      input logic [WORD_WIDTH-1:0] w,
      input logic [WORD_WIDTH-1:0] sum,
      input logic [WORD_WIDTH-1:0] ka,
      input logic [WORD_WIDTH-1:0] kb
   );
      mix_half = ((w << 4) + ka) ^ (w + sum) ^ ((w >> 5) + kb);
   endfunction

endpackage

`default_nettype wire

FILE: src/tea_half_round.sv
`timescale 1ns / 1ps
`default_nettype none

module tea_half_round #(
   parameter logic        ODD_HALF = 1'b0,
   parameter logic [31:0] ENC_SUM  = 32'h0,
   parameter logic [31:0] DEC_SUM  = 32'h0
) (
   input  wire               clock,
   input  wire               reset,
   input  tea_pkg::key_type  key,
   input  wire               up_valid,
   input  tea_pkg::item_type up_item,
   output logic              up_ready,
   output logic              down_valid,
   output tea_pkg::item_type down_item,
   input  wire               down_ready
);

   logic              valid_ff;
   logic              valid_in;
   tea_pkg::item_type item_ff;
   tea_pkg::item_type item_in;

   logic        decrypt;
   logic        update_a;
   logic [31:0] sum;
   logic [31:0] mix;

   // The stage may take a new item when it is empty or its item moves on.
   assign up_ready = !valid_ff || down_ready;

   always_comb begin
      decrypt  = (up_item.func == tea_pkg::FUNC_DECRYPT);
      sum      = decrypt ? DEC_SUM : ENC_SUM;
      // Decryption runs the two halves of each round in reverse order.
      update_a = ODD_HALF ? decrypt : !decrypt;
      if (update_a) begin
         mix = tea_pkg::mix_half(up_item.b, sum, key.k0, key.k1);
      end else begin
         mix = tea_pkg::mix_half(up_item.a, sum, key.k2, key.k3);
      end
      item_in = up_item;
      if (update_a) begin
         item_in.a = decrypt ? up_item.a - mix : up_item.a + mix;
      end else begin
         item_in.b = decrypt ? up_item.b - mix : up_item.b + mix;
      end
      valid_in = up_ready ? up_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         item_ff <= item_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_item  = item_ff;

endmodule

`default_nettype wire

FILE: src/tea_block_cipher.sv
// TEA block cipher, 64-bit block and 128-bit key, as a streaming pipeline.
// Input channel req_: one block per item, req_tdata holds the two words and
// req_tuser selects encryption (0) or decryption (1).
// Result channel rsp_: one result block per item, in input order.
// Configuration port csr_: a write with csr_we high stores csr_wdata into
// key word csr_index; the user must change keys only while no item is in
// flight; the block itself does not enforce it. Each half-round of the
// cipher is one register stage, so the pipeline is 2*CYCLES stages deep
// (32 rounds by default). One item may enter every cycle while req_tready
// is high. Per stage the data path is one add, xor and add/subtract deep,
// while ready runs combinationally back through every stage. The last
// stage doubles as the output register. When the receiver stalls, items
// pile up stage by stage into empty slots, and req_tready falls only when
// every stage holds an item. Nothing is dropped or repeated. Reset clears
// all stage valid bits and the key words to zero.
`timescale 1ns / 1ps
`default_nettype none

module tea_block_cipher #(
   parameter int CYCLES = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_we,
   input  wire  [1:0]  csr_index,
   input  wire  [31:0] csr_wdata,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [63:0] req_tdata,   // word_first [31:0], word_second [63:32]
   input  wire         req_tuser,   // func [0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [63:0] rsp_tdata    // out_first [31:0], out_second [63:32]
);

   localparam int STAGES = 2 * CYCLES;

   tea_pkg::key_type  key_ff;
   logic [STAGES:0]   link_valid;
   logic [STAGES:0]   link_ready;
   tea_pkg::item_type link_item [STAGES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            tea_pkg::KEY_WORD_0_INDEX: key_ff.k0 <= csr_wdata;
            tea_pkg::KEY_WORD_1_INDEX: key_ff.k1 <= csr_wdata;
            tea_pkg::KEY_WORD_2_INDEX: key_ff.k2 <= csr_wdata;
            tea_pkg::KEY_WORD_3_INDEX: key_ff.k3 <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign link_valid[0]  = req_tvalid;
   assign link_item[0]   = '{func: req_tuser, a: req_tdata[31:0], b: req_tdata[63:32]};
   assign req_tready     = link_ready[0];
   assign link_ready[STAGES] = rsp_tready;

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      localparam int ROUND = k / 2;
      localparam logic [31:0] ENC_SUM = 32'(64'(ROUND + 1) * 64'(tea_pkg::DELTA));
      localparam logic [31:0] DEC_SUM = 32'(64'(CYCLES - ROUND) * 64'(tea_pkg::DELTA));

      tea_half_round #(
         .ODD_HALF (1'(k % 2)),
         .ENC_SUM  (ENC_SUM),
         .DEC_SUM  (DEC_SUM)
      ) u_half (
         .clock      (clock),
         .reset      (reset),
         .key        (key_ff),
         .up_valid   (link_valid[k]),
         .up_item    (link_item[k]),
         .up_ready   (link_ready[k]),
         .down_valid (link_valid[k+1]),
         .down_item  (link_item[k+1]),
         .down_ready (link_ready[k+1])
      );
   end

   assign rsp_tvalid = link_valid[STAGES];
   assign rsp_tdata  = {link_item[STAGES].b, link_item[STAGES].a};

`ifndef SYNTHESIS
   // An accepted item must occupy the first stage on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> link_valid[1])
      else $error("accepted item did not enter the first stage");

   // With the pipeline empty and no item taken, no result can appear.
   assert property (@(posedge clock) disable iff (reset)
      (!(|link_valid[STAGES:1]) && !req_tvalid) |=> !rsp_tvalid)
      else $error("result appeared from an empty pipeline");

   // Back-pressure at the input only when the pipeline holds work.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (|link_valid[STAGES:1]))
      else $error("input stalled while pipeline is empty");
`endif

endmodule

`default_nettype wire
